FILE: rtl/dcw_pkg.sv
// dcw_pkg: shared types and constants for the drive control word machine.
// No dependencies; imported by dcw_step and drive_control_word_fsm.
package dcw_pkg;

    localparam int SPEED_WIDTH_DEF = 16;
    localparam int FB_REPORT_BITS  = 16;

    typedef enum logic [2:0] {
        MODE_OFF   = 3'd0,
        MODE_READY = 3'd1,
        MODE_RUN   = 3'd2,
        MODE_RAMP  = 3'd3,
        MODE_COAST = 3'd4,
        MODE_FAULT = 3'd5,
        MODE_IDENT = 3'd6
    } mode_t;

    typedef struct packed {
        logic speed_mode_on;
        logic motor_identified;
        logic coasting;
        logic identifying;
        logic running;
        logic enabled;
        logic drive_fault;
    } status_t;

    typedef struct packed {
        logic ack_faults;
        logic enable_drive;
        logic on_off1;
        logic off2;
        logic identify;
        logic speed_mode;
    } ctrl_t;

endpackage

FILE: rtl/dcw_if.sv
// dcw_if: valid/ready channels for control words in and status words out.
// Depends on nothing; the speed fields follow SPEED_WIDTH.
interface dcw_cmd_if #(parameter int SPEED_WIDTH = 16);
    logic                          valid;
    logic                          ready;
    logic                          ack_faults;
    logic                          enable_drive;
    logic                          on_off1;
    logic                          off2;
    logic                          identify;
    logic                          speed_mode;
    logic signed [SPEED_WIDTH-1:0] speed_setpoint;

    modport source (output valid, ack_faults, enable_drive, on_off1, off2, identify,
                    speed_mode, speed_setpoint, input ready);
    modport sink (input valid, ack_faults, enable_drive, on_off1, off2, identify,
                  speed_mode, speed_setpoint, output ready);
endinterface

interface dcw_stat_if #(parameter int SPEED_WIDTH = 16);
    logic                          valid;
    logic                          ready;
    logic [2:0]                    mode;
    logic                          drive_fault;
    logic                          enabled;
    logic                          running;
    logic                          identifying;
    logic                          coasting;
    logic                          motor_identified;
    logic                          speed_mode_on;
    logic signed [SPEED_WIDTH-1:0] speed_feedback;

    modport source (output valid, mode, drive_fault, enabled, running, identifying,
                    coasting, motor_identified, speed_mode_on, speed_feedback,
                    input ready);
    modport sink (input valid, mode, drive_fault, enabled, running, identifying,
                  coasting, motor_identified, speed_mode_on, speed_feedback,
                  output ready);
endinterface

FILE: rtl/dcw_step.sv
// dcw_step: next mode, status and feedback for one control word.
// Purely combinational; uses dcw_pkg.
module dcw_step
    import dcw_pkg::*;
#(
    parameter int SPEED_WIDTH = SPEED_WIDTH_DEF
)
(
    input  mode_t                         mode_cur,
    input  status_t                       status_cur,
    input  logic signed [SPEED_WIDTH-1:0] fb_cur,
    input  ctrl_t                         ctrl,
    input  logic signed [SPEED_WIDTH-1:0] setp,
    output mode_t                         mode_nxt,
    output status_t                       status_nxt,
    output logic signed [SPEED_WIDTH-1:0] fb_nxt
);

    // next mode; in ready the earlier check wins
    always_comb
    begin
        mode_nxt = mode_cur;
        unique case (mode_cur)
            MODE_OFF:
            begin
                if (ctrl.enable_drive && !ctrl.on_off1 && !ctrl.off2)
                    mode_nxt = MODE_READY;
            end
            MODE_READY:
            begin
                priority if (ctrl.identify)
                    mode_nxt = MODE_IDENT;
                else if (ctrl.on_off1)
                    mode_nxt = MODE_RUN;
                else if (!ctrl.enable_drive || ctrl.off2)
                    mode_nxt = MODE_OFF;
                else
                    mode_nxt = MODE_READY;
            end
            MODE_RUN:
            begin
                priority if (ctrl.off2)
                    mode_nxt = MODE_COAST;
                else if (!ctrl.on_off1)
                    mode_nxt = MODE_RAMP;
                else
                    mode_nxt = MODE_RUN;
            end
            MODE_RAMP:  mode_nxt = MODE_READY;
            MODE_COAST: mode_nxt = MODE_OFF;
            MODE_FAULT: mode_nxt = MODE_COAST;
            MODE_IDENT: mode_nxt = MODE_READY;
            default:    mode_nxt = MODE_OFF;
        endcase
    end

    // status bits and feedback
    always_comb
    begin
        status_nxt = status_cur;
        fb_nxt     = fb_cur;
        unique case (mode_cur)
            MODE_OFF:
            begin
                if (ctrl.ack_faults)
                    status_nxt.drive_fault = 1'b0;
                if (ctrl.enable_drive && !ctrl.on_off1 && !ctrl.off2)
                    status_nxt.enabled = 1'b1;
            end
            MODE_READY:
            begin
                if (!ctrl.enable_drive || ctrl.off2)
                    status_nxt.enabled = 1'b0;
                if (ctrl.on_off1)
                    status_nxt.running = 1'b1;
                if (ctrl.identify)
                    status_nxt.identifying = 1'b1;
            end
            MODE_RUN:
            begin
                fb_nxt = setp;
                if (!ctrl.on_off1 || ctrl.off2)
                    status_nxt.running = 1'b0;
                if (ctrl.off2)
                    status_nxt.coasting = 1'b1;
            end
            MODE_COAST:
            begin
                status_nxt.coasting = 1'b0;
                status_nxt.enabled  = 1'b0;
            end
            MODE_IDENT:
            begin
                status_nxt.identifying      = 1'b0;
                status_nxt.motor_identified = 1'b1;
            end
            default:
            begin
                status_nxt = status_cur;
            end
        endcase
        status_nxt.speed_mode_on = ctrl.speed_mode;
    end

endmodule

FILE: rtl/drive_control_word_fsm.sv
// Drive control word sequencing machine: one status word per control word.
// From acceptance to status valid a word passes the input register, then the state update.
// Throughput one word per cycle; the input stage stalls only while a status word waits.
// The state registers double as the output register: a word is applied only when the
// previous status word is taken or absent. Asynchronous active-low reset: mode off,
// status bits and speed feedback cleared, both stages empty.
module drive_control_word_fsm
    import dcw_pkg::*;
#(
    parameter int SPEED_WIDTH = SPEED_WIDTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    dcw_cmd_if.sink           cmd,
    dcw_stat_if.source        stat
);

    localparam int FB_BITS = (SPEED_WIDTH < FB_REPORT_BITS) ? SPEED_WIDTH : FB_REPORT_BITS;
    localparam logic [SPEED_WIDTH-1:0] FB_MASK = {SPEED_WIDTH{1'b1}} >> (SPEED_WIDTH - FB_BITS);

    logic                          in_valid_reg;
    ctrl_t                         ctrl_reg;
    logic signed [SPEED_WIDTH-1:0] setp_reg;

    logic                          out_valid_reg;
    mode_t                         mode_reg;
    status_t                       status_reg;
    logic signed [SPEED_WIDTH-1:0] feedback_reg;

    mode_t                         mode_next;
    status_t                       status_next;
    logic signed [SPEED_WIDTH-1:0] feedback_next;

    logic advance;
    logic in_take;

    assign advance   = in_valid_reg && (!out_valid_reg || stat.ready);
    assign cmd.ready = !in_valid_reg || advance;
    assign in_take   = cmd.valid && cmd.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (cmd.ready)
            in_valid_reg <= cmd.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            ctrl_reg <= '{ack_faults:   cmd.ack_faults,
                          enable_drive: cmd.enable_drive,
                          on_off1:      cmd.on_off1,
                          off2:         cmd.off2,
                          identify:     cmd.identify,
                          speed_mode:   cmd.speed_mode};
            setp_reg <= cmd.speed_setpoint;
        end
    end

    dcw_step #(
        .SPEED_WIDTH (SPEED_WIDTH)
    ) u_step (
        .mode_cur   (mode_reg),
        .status_cur (status_reg),
        .fb_cur     (feedback_reg),
        .ctrl       (ctrl_reg),
        .setp       (setp_reg),
        .mode_nxt   (mode_next),
        .status_nxt (status_next),
        .fb_nxt     (feedback_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_OFF;
            status_reg    <= '0;
            feedback_reg  <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                mode_reg      <= mode_next;
                status_reg    <= status_next;
                feedback_reg  <= feedback_next;
            end
            else if (stat.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign stat.valid            = out_valid_reg;
    assign stat.mode             = mode_reg;
    assign stat.drive_fault      = status_reg.drive_fault;
    assign stat.enabled          = status_reg.enabled;
    assign stat.running          = status_reg.running;
    assign stat.identifying      = status_reg.identifying;
    assign stat.coasting         = status_reg.coasting;
    assign stat.motor_identified = status_reg.motor_identified;
    assign stat.speed_mode_on    = status_reg.speed_mode_on;
    assign stat.speed_feedback   = feedback_reg & FB_MASK;

`ifndef SYNTHESIS
    a_fault_unreached: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg != MODE_FAULT)
        else $error("fault mode entered");

    a_run_flag: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_RUN |-> status_reg.running)
        else $error("run mode without running flag");

    a_ident_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        status_reg.motor_identified |=> status_reg.motor_identified)
        else $error("motor identified flag dropped");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !stat.ready |=> $stable(mode_reg) && $stable(status_reg))
        else $error("state moved while status word waiting");
`endif

endmodule

FILE: dv/drive_control_word_fsm_test.sv
// Self-checking testbench for drive_control_word_fsm: directed mode walks, then biased random words.
// A scoreboard class predicts each status word; the sender and receiver idle and stall at random.
// Depends on rtl/dcw_pkg.sv, rtl/dcw_if.sv, rtl/dcw_step.sv and rtl/drive_control_word_fsm.sv.
module drive_control_word_fsm_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dcw_pkg::*;

    localparam int SPW = 16;

    typedef struct {
        ctrl_t                 ctl;
        logic signed [SPW-1:0] setpoint;
    } cmd_word_t;

    typedef struct {
        logic [2:0]            mode;
        status_t               bits;
        logic signed [SPW-1:0] feedback;
    } stat_word_t;

    class drive_status_board;
        mode_t                 mode;
        status_t               bits;
        logic signed [SPW-1:0] feedback;
        stat_word_t            due_status[$];
        int                    errors;

        function new();
            mode     = MODE_OFF;
            bits     = '0;
            feedback = '0;
            errors   = 0;
        endfunction

        // Advance the drive state by one control word and queue the status it yields.
        function void take_command(cmd_word_t w);
            stat_word_t s;
            case (mode)
                MODE_READY:
                begin
                    if (!w.ctl.enable_drive || w.ctl.off2)
                    begin
                        mode         = MODE_OFF;
                        bits.enabled = 1'b0;
                    end
                    if (w.ctl.on_off1)
                    begin
                        mode         = MODE_RUN;
                        bits.running = 1'b1;
                    end
                    if (w.ctl.identify)
                    begin
                        mode             = MODE_IDENT;
                        bits.identifying = 1'b1;
                    end
                end
                MODE_RUN:
                begin
                    feedback = w.setpoint;
                    if (!w.ctl.on_off1)
                    begin
                        mode         = MODE_RAMP;
                        bits.running = 1'b0;
                    end
                    if (w.ctl.off2)
                    begin
                        mode          = MODE_COAST;
                        bits.running  = 1'b0;
                        bits.coasting = 1'b1;
                    end
                end
                MODE_RAMP:
                    mode = MODE_READY;
                MODE_COAST:
                begin
                    mode          = MODE_OFF;
                    bits.coasting = 1'b0;
                    bits.enabled  = 1'b0;
                end
                MODE_FAULT:
                    mode = MODE_COAST;
                MODE_IDENT:
                begin
                    bits.identifying      = 1'b0;
                    bits.motor_identified = 1'b1;
                    mode                  = MODE_READY;
                end
                MODE_OFF:
                begin
                    if (w.ctl.ack_faults)
                        bits.drive_fault = 1'b0;
                    if (w.ctl.enable_drive && !w.ctl.on_off1 && !w.ctl.off2)
                    begin
                        mode         = MODE_READY;
                        bits.enabled = 1'b1;
                    end
                end
                default:
                    mode = MODE_OFF;
            endcase
            bits.speed_mode_on = w.ctl.speed_mode;
            s.mode     = mode;
            s.bits     = bits;
            s.feedback = feedback;
            due_status.push_back(s);
        endfunction

        local function void compare_field(string field, logic signed [31:0] exp_v,
                                          logic signed [31:0] got_v);
            if (got_v !== exp_v)
            begin
                $error("%s: expected %0d, got %0d", field, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_status(stat_word_t got);
            stat_word_t e;
            if (due_status.size() == 0)
            begin
                $error("status word with none expected: mode %0d", got.mode);
                errors++;
                return;
            end
            e = due_status.pop_front();
            compare_field("mode", 32'(e.mode), 32'(got.mode));
            compare_field("drive_fault", 32'(e.bits.drive_fault), 32'(got.bits.drive_fault));
            compare_field("enabled", 32'(e.bits.enabled), 32'(got.bits.enabled));
            compare_field("running", 32'(e.bits.running), 32'(got.bits.running));
            compare_field("identifying", 32'(e.bits.identifying), 32'(got.bits.identifying));
            compare_field("coasting", 32'(e.bits.coasting), 32'(got.bits.coasting));
            compare_field("motor_identified", 32'(e.bits.motor_identified),
                          32'(got.bits.motor_identified));
            compare_field("speed_mode_on", 32'(e.bits.speed_mode_on),
                          32'(got.bits.speed_mode_on));
            compare_field("speed_feedback", 32'(e.feedback), 32'(got.feedback));
        endfunction

        function int pending();
            return due_status.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   random_on = 1'b0;
    int   burst_left = 0;

    drive_status_board sb = new();

    dcw_cmd_if  #(.SPEED_WIDTH(SPW)) cmd ();
    dcw_stat_if #(.SPEED_WIDTH(SPW)) stat ();

    drive_control_word_fsm #(.SPEED_WIDTH(SPW)) u_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic cmd_word_t mk(bit ack, bit en, bit on1, bit off2, bit ident, bit smode,
                                     logic signed [SPW-1:0] sp);
        cmd_word_t w;
        w.ctl      = '{ack_faults: ack, enable_drive: en, on_off1: on1, off2: off2,
                       identify: ident, speed_mode: smode};
        w.setpoint = sp;
        return w;
    endfunction

    // Mostly words that move the machine on from its current mode, the rest noise.
    function automatic cmd_word_t pick_word(mode_t m);
        cmd_word_t w;
        w.ctl = ctrl_t'(6'($urandom_range(0, 63)));
        case ($urandom_range(0, 9))
            0:       w.setpoint = 16'sh7fff;
            1:       w.setpoint = 16'sh8000;
            2:       w.setpoint = '0;
            3:       w.setpoint = '1;
            default: w.setpoint = SPW'($urandom);
        endcase
        if ($urandom_range(0, 99) < 80)
        begin
            case (m)
                MODE_OFF:
                begin
                    w.ctl.enable_drive = 1'b1;
                    w.ctl.on_off1      = 1'b0;
                    w.ctl.off2         = 1'b0;
                end
                MODE_READY:
                    case ($urandom_range(0, 3))
                        0:
                        begin
                            w.ctl.enable_drive = 1'b1;
                            w.ctl.off2         = 1'b0;
                            w.ctl.on_off1      = 1'b1;
                            w.ctl.identify     = 1'b0;
                        end
                        1:
                            w.ctl.identify = 1'b1;
                        2:
                        begin
                            w.ctl.enable_drive = 1'b1;
                            w.ctl.off2         = 1'b0;
                            w.ctl.on_off1      = 1'b0;
                            w.ctl.identify     = 1'b0;
                        end
                        default:
                            ;
                    endcase
                MODE_RUN:
                    case ($urandom_range(0, 7))
                        6:
                        begin
                            w.ctl.on_off1 = 1'b0;
                            w.ctl.off2    = 1'b0;
                        end
                        7:
                            w.ctl.off2 = 1'b1;
                        default:
                        begin
                            w.ctl.on_off1 = 1'b1;
                            w.ctl.off2    = 1'b0;
                        end
                    endcase
                default:
                    ;
            endcase
        end
        return w;
    endfunction

    // Called at a rising edge; returns at the edge where the word is taken.
    task automatic send(cmd_word_t w);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                cmd.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        cmd.valid          <= 1'b1;
        cmd.ack_faults     <= w.ctl.ack_faults;
        cmd.enable_drive   <= w.ctl.enable_drive;
        cmd.on_off1        <= w.ctl.on_off1;
        cmd.off2           <= w.ctl.off2;
        cmd.identify       <= w.ctl.identify;
        cmd.speed_mode     <= w.ctl.speed_mode;
        cmd.speed_setpoint <= w.setpoint;
        do
            @(posedge clk);
        while (!cmd.ready);
        sb.take_command(w);
    endtask

    task automatic drain();
        cmd.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        cmd.valid          <= 1'b0;
        cmd.ack_faults     <= 1'b0;
        cmd.enable_drive   <= 1'b0;
        cmd.on_off1        <= 1'b0;
        cmd.off2           <= 1'b0;
        cmd.identify       <= 1'b0;
        cmd.speed_mode     <= 1'b0;
        cmd.speed_setpoint <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(mk(1, 0, 0, 0, 0, 0, 16'sd0));
        send(mk(0, 1, 1, 0, 0, 1, 16'sh7fff));
        send(mk(0, 1, 0, 1, 0, 0, 16'sd0));
        send(mk(1, 1, 0, 0, 0, 1, 16'sd100));
        send(mk(0, 1, 0, 0, 0, 0, 16'sd5));
        send(mk(0, 1, 1, 0, 0, 1, -16'sd1));
        send(mk(0, 1, 1, 0, 0, 0, 16'sh7fff));
        send(mk(0, 1, 1, 0, 0, 1, 16'sh8000));
        send(mk(0, 1, 0, 0, 0, 0, 16'sd1234));
        send(mk(0, 1, 1, 1, 1, 1, 16'sd0));
        send(mk(0, 1, 0, 0, 1, 0, 16'sd0));
        send(mk(1, 0, 1, 1, 1, 1, 16'sd0));
        // ready with disable, run and identify all asking: identify wins
        send(mk(0, 0, 1, 0, 1, 0, 16'sd0));
        send(mk(0, 0, 0, 0, 0, 0, 16'sd0));
        send(mk(0, 1, 1, 1, 0, 1, 16'sd77));
        send(mk(0, 1, 1, 1, 0, 0, -16'sd77));
        send(mk(0, 1, 0, 0, 0, 1, 16'sd0));
        send(mk(0, 1, 0, 0, 0, 0, 16'sd0));
        send(mk(0, 0, 0, 0, 0, 0, 16'sd0));
        send(mk(0, 1, 0, 0, 0, 1, 16'sd0));
        send(mk(0, 1, 1, 0, 0, 0, 16'sd0));
        // ramp stop and coast down together: coast wins
        send(mk(0, 0, 0, 1, 0, 1, 16'sd0));
        send(mk(1, 1, 1, 1, 1, 1, 16'sh8000));

        random_on = 1'b1;
        for (int i = 0; i < 600; i++)
        begin
            if (i == 300)
                drain();
            send(pick_word(sb.mode));
        end

        drain();
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Receiver: segments of free flow, random stalls and heavy stalls, plus one long hold-off.
    initial
    begin
        int  seg_left;
        int  style;
        int  rx_cycles;
        seg_left  = 0;
        style     = 0;
        rx_cycles = 0;
        stat.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(20, 100);
                style    = $urandom_range(0, 2);
            end
            seg_left--;
            if (random_on)
                rx_cycles++;
            if (rx_cycles == 150)
            begin
                stat.ready <= 1'b0;
                repeat (120) @(posedge clk);
                rx_cycles++;
            end
            case (style)
                0:       stat.ready <= 1'b1;
                1:       stat.ready <= 1'($urandom_range(0, 1));
                default: stat.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    initial
    begin
        stat_word_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && stat.valid && stat.ready)
            begin
                got.mode     = stat.mode;
                got.bits     = {stat.speed_mode_on, stat.motor_identified, stat.coasting,
                                stat.identifying, stat.running, stat.enabled,
                                stat.drive_fault};
                got.feedback = stat.speed_feedback;
                sb.check_status(got);
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
